FILE: hdl/gss_pkg.sv
// ---------------------------------------------------------------------------
// gss_pkg
// Shared constants and types for the Gauss-Seidel solver unit.
// ---------------------------------------------------------------------------
package gss_pkg;
   localparam int SIZE      = 3;
   localparam int FRAC_BITS = 16;
   localparam int COLS      = SIZE + 1;
   localparam int IDX_W     = 2;
   localparam int CSTORE_DEPTH = SIZE * COLS;
   localparam int CADDR_W   = $clog2(CSTORE_DEPTH);
   localparam int XADDR_W   = $clog2(SIZE);
   localparam int SWEEP_W   = 8;
   localparam logic [SWEEP_W-1:0] SWEEP_RESET = 8'd32;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SOLVE = 1'b1;
   localparam logic [0:0] REG_SWEEP_COUNT = 1'b0;

   // divider request/response between sequencer and divider
   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sd2147483647) r = 32'h7fffffff;
      else if (v < -66'sd2147483648) r = 32'h80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

FILE: hdl/gss_ram.sv
// ---------------------------------------------------------------------------
// gss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module gss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hdl/gss_div.sv
// ---------------------------------------------------------------------------
// gss_div
// Restoring divider: (|a| << FRAC_BITS) / |d|, one quotient bit a cycle,
// signed and saturated to 32 bits.
// ---------------------------------------------------------------------------
module gss_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gss_pkg::div_req_type req,
   output gss_pkg::div_rsp_type rsp
);
   localparam int QW = 32 + gss_pkg::FRAC_BITS;

   logic [QW-1:0] quo_ff, quo_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic [QW-1:0] q;

   // one bit per step
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[31:0], quo_ff[QW-1]};
      if (req.start) begin
         quo_in  = {(req.num[31] ? 32'(-req.num) : req.num),
                    {gss_pkg::FRAC_BITS{1'b0}}};
         den_in  = req.den[31] ? 32'(-req.den) : req.den;
         neg_in  = req.num[31] ^ req.den[31];
         rem_in  = '0;
         cnt_in  = 7'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   // sign and saturate
   always_comb begin
      q = quo_ff;
      rsp.done = done_ff;
      if (neg_ff) begin
         if (q >= QW'(33'h80000000)) rsp.quot = 32'h80000000;
         else rsp.quot = 32'(-q);
      end else begin
         if (q > QW'(32'h7fffffff)) rsp.quot = 32'h7fffffff;
         else rsp.quot = q[31:0];
      end
   end
endmodule

FILE: hdl/gss_core.sv
// ---------------------------------------------------------------------------
// gss_core
// Sequencer: normalizes rows into a scratch RAM, runs the sweeps reading
// and writing the solution RAM, then emits the results.
// ---------------------------------------------------------------------------
module gss_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gss_pkg::SWEEP_W-1:0]   sweep_count,
   output logic                          busy,
   output logic [gss_pkg::CADDR_W-1:0]   crd_addr,
   input  logic [31:0]                   crd_data,
   output logic                          rsp_valid,
   output logic [gss_pkg::IDX_W-1:0]     rsp_index,
   output logic [31:0]                   rsp_value,
   output logic                          rsp_status,
   output logic                          rsp_last
);
   localparam int CA = gss_pkg::CADDR_W;
   localparam int XA = gss_pkg::XADDR_W;

   localparam logic [3:0] ST_IDLE = 4'd0, ST_RDDIAG = 4'd1, ST_DIAG = 4'd2,
      ST_RDE = 4'd3, ST_DIV = 4'd4, ST_DIVW = 4'd5, ST_SWRD = 4'd6,
      ST_SWMUL = 4'd7, ST_SWACC = 4'd8, ST_SWWR = 4'd9, ST_OUTRD = 4'd10,
      ST_OUT = 4'd11, ST_CLR = 4'd12, ST_SWUPD = 4'd13;

   logic [3:0]  st_ff, st_in;
   logic [XA-1:0] row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic [XA-1:0] k_ff, k_in;
   logic [31:0] diag_ff, diag_in;
   logic        dz_ff, dz_in;
   logic        status_ff, status_in;
   logic [gss_pkg::SWEEP_W-1:0] sw_ff, sw_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0] cval_ff, cval_in;
   logic        cv_neg;
   logic [31:0] cmag, xmag;
   logic [63:0] mag;
   gss_pkg::div_req_type dreq;
   gss_pkg::div_rsp_type drsp;

   // scratch RAM: normalized matrix (row*COLS+col), solution RAM
   logic          nwe;  logic [CA-1:0] nwa, nra;  logic [31:0] nwd, nrd;
   logic          xwe;  logic [XA-1:0] xwa, xra;  logic [31:0] xwd, xrd;
   logic [CA-1:0] row_base;
   logic [CA-1:0] kaddr;

   gss_ram #(.WIDTH(32), .DEPTH(gss_pkg::CSTORE_DEPTH)) u_norm (
      .clock(clock), .wr_en(nwe), .wr_addr(nwa), .wr_data(nwd),
      .rd_addr(nra), .rd_data(nrd));
   gss_ram #(.WIDTH(32), .DEPTH(gss_pkg::SIZE)) u_sol (
      .clock(clock), .wr_en(xwe), .wr_addr(xwa), .wr_data(xwd),
      .rd_addr(xra), .rd_data(xrd));
   gss_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign row_base = CA'(row_ff * gss_pkg::COLS);
   assign kaddr    = CA'(row_base + CA'(k_ff));
   assign busy     = (st_ff != ST_IDLE);
   assign cv_neg   = cval_ff[31] ^ xrd[31];

   // sequencer
   always_comb begin
      st_in = st_ff; row_in = row_ff; col_in = col_ff; k_in = k_ff;
      diag_in = diag_ff; dz_in = dz_ff; status_in = status_ff; sw_in = sw_ff;
      acc_in = acc_ff; prod_in = prod_ff; cval_in = cval_ff;
      crd_addr = row_base; nra = kaddr; xra = k_ff;
      nwe = 1'b0; nwa = CA'(row_base + CA'(col_ff)); nwd = drsp.quot;
      xwe = 1'b0; xwa = row_ff; xwd = '0;
      dreq = '0; dreq.num = crd_data; dreq.den = diag_ff;
      rsp_valid = 1'b0; rsp_index = gss_pkg::IDX_W'(row_ff);
      rsp_value = xrd; rsp_status = status_ff;
      rsp_last = (row_ff == XA'(gss_pkg::SIZE - 1));
      cmag = '0; xmag = '0; mag = '0;
      unique case (st_ff)
         ST_IDLE: if (start) begin
            row_in = '0; status_in = 1'b0; st_in = ST_CLR;
         end
         // zero the iterate
         ST_CLR: begin
            xwe = 1'b1; xwa = row_ff;
            if (row_ff == XA'(gss_pkg::SIZE - 1)) begin
               row_in = '0; st_in = ST_RDDIAG;
            end else row_in = row_ff + 1'b1;
         end
         ST_RDDIAG: begin
            crd_addr = CA'(row_base + CA'(row_ff)); st_in = ST_DIAG;
         end
         ST_DIAG: begin
            diag_in = crd_data; dz_in = (crd_data == 32'd0);
            if (crd_data == 32'd0) status_in = 1'b1;
            col_in = '0; st_in = ST_RDE;
         end
         ST_RDE: begin
            crd_addr = CA'(row_base + CA'(col_ff)); st_in = ST_DIV;
         end
         ST_DIV: begin
            if (dz_ff || col_ff == 3'(row_ff)) begin
               nwe = 1'b1; nwd = '0; st_in = ST_DIVW;
            end else begin
               dreq.start = 1'b1; st_in = ST_DIVW;
            end
         end
         // wait for quotient, advance column / row
         ST_DIVW: begin
            if (dz_ff || col_ff == 3'(row_ff) || drsp.done) begin
               if (!(dz_ff || col_ff == 3'(row_ff))) nwe = 1'b1;
               if (col_ff == 3'(gss_pkg::SIZE)) begin
                  if (row_ff == XA'(gss_pkg::SIZE - 1)) begin
                     row_in = '0; k_in = '0; sw_in = sweep_count; acc_in = '0;
                     st_in = (sweep_count == '0) ? ST_OUTRD : ST_SWRD;
                  end else begin
                     row_in = row_ff + 1'b1; st_in = ST_RDDIAG;
                  end
               end else begin
                  col_in = col_ff + 3'd1; st_in = ST_RDE;
               end
            end
         end
         // read c_jk and x_k
         ST_SWRD: st_in = ST_SWMUL;
         ST_SWMUL: begin
            cval_in = nrd;
            st_in = ST_SWACC;
         end
         ST_SWACC: begin
            cmag = cval_ff[31] ? 32'(-cval_ff) : cval_ff;
            xmag = xrd[31] ? 32'(-xrd) : xrd;
            mag = {32'd0, cmag} * {32'd0, xmag};
            prod_in = cv_neg ? -$signed(mag >> gss_pkg::FRAC_BITS)
                             : $signed(mag >> gss_pkg::FRAC_BITS);
            st_in = ST_SWWR;
         end
         ST_SWWR: begin
            acc_in = acc_ff + 66'(prod_ff);
            if (k_ff == XA'(gss_pkg::SIZE - 1)) begin
               // fetch b_j for the update
               nra = CA'(row_base + CA'(gss_pkg::SIZE));
               st_in = ST_SWUPD;
            end else begin
               k_in = k_ff + 1'b1; st_in = ST_SWRD;
            end
         end
         ST_SWUPD: begin
            // write x_j = b_j - acc
            xwe = 1'b1; xwa = row_ff;
            xwd = gss_pkg::sat32($signed({{34{nrd[31]}}, nrd}) - acc_ff);
            acc_in = '0; k_in = '0;
            if (row_ff == XA'(gss_pkg::SIZE - 1)) begin
               row_in = '0;
               sw_in = sw_ff - 1'b1;
               st_in = (sw_ff == 8'd1) ? ST_OUTRD : ST_SWRD;
            end else begin
               row_in = row_ff + 1'b1; st_in = ST_SWRD;
            end
         end
         ST_OUTRD: begin
            xra = row_ff; st_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (row_ff == XA'(gss_pkg::SIZE - 1)) st_in = ST_IDLE;
            else begin
               row_in = row_ff + 1'b1; st_in = ST_OUTRD;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; status_ff <= 1'b0; row_ff <= '0;
      end else begin
         st_ff <= st_in; status_ff <= status_in; row_ff <= row_in;
      end
      col_ff <= col_in; k_ff <= k_in; diag_ff <= diag_in; dz_ff <= dz_in;
      sw_ff <= sw_in; acc_ff <= acc_in; prod_ff <= prod_in; cval_ff <= cval_in;
   end

   // results only leave while solving, last marks the final row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside solve");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy) else $error("solve did not end");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE && start) |=> busy) else $error("solve not started");
endmodule

FILE: hdl/gauss_seidel_solver_unit.sv
// ---------------------------------------------------------------------------
// gauss_seidel_solver_unit
// Gauss-Seidel solver for a 3x3 system in signed Q16.16.
// ---------------------------------------------------------------------------
// Usage: drive req_* with start high while busy is low. A load transaction
// (operation 0) writes one augmented-matrix entry; loads may follow back
// to back. A solve transaction (operation 1) raises busy, clears the
// iterate, normalizes every row through a bit-serial divider, runs
// sweep_count sweeps, then emits SIZE results, each marked by rsp_valid
// for one cycle; rsp_last_flag marks the final one. The receiver cannot
// stall the results. The CSR port (psel/penable/pwrite) holds sweep_count
// at address 0 (reset 32). Reset returns to idle; the matrix memory is
// undefined until loaded.
// ---------------------------------------------------------------------------
module gauss_seidel_solver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [1:0]  req_row_index,
   input  logic [1:0]  req_column_index,
   input  logic signed [31:0] req_entry_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_unknown_index,
   output logic signed [31:0] rsp_solution_value,
   output logic        rsp_status,
   output logic        rsp_last_flag,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [gss_pkg::SWEEP_W-1:0] sweep_ff;
   logic accept, load_ok, solve_go;
   logic [gss_pkg::CADDR_W-1:0] crd_addr;
   logic [31:0] crd_data;
   logic [gss_pkg::CADDR_W-1:0] cwa;

   assign pready  = 1'b1;
   assign prdata  = (paddr[1] == gss_pkg::REG_SWEEP_COUNT) ? {24'd0, sweep_ff} : 32'd0;
   assign accept  = start && !busy;
   assign solve_go = accept && (req_operation == gss_pkg::OP_SOLVE);
   assign load_ok = accept && (req_operation == gss_pkg::OP_LOAD)
                 && (req_row_index < 2'(gss_pkg::SIZE))
                 && ({1'b0, req_column_index} <= 3'(gss_pkg::SIZE));
   assign cwa = gss_pkg::CADDR_W'(req_row_index * gss_pkg::COLS + req_column_index);

   // sweep count register
   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= gss_pkg::SWEEP_RESET;
      else if (psel && penable && pwrite && paddr[1] == gss_pkg::REG_SWEEP_COUNT)
         sweep_ff <= pwdata[7:0];
   end

   gss_ram #(.WIDTH(32), .DEPTH(gss_pkg::CSTORE_DEPTH)) u_coef (
      .clock(clock), .wr_en(load_ok), .wr_addr(cwa), .wr_data(req_entry_value),
      .rd_addr(crd_addr), .rd_data(crd_data));

   gss_core u_core (
      .clock(clock), .reset(reset), .start(solve_go), .sweep_count(sweep_ff),
      .busy(busy), .crd_addr(crd_addr), .crd_data(crd_data),
      .rsp_valid(rsp_valid), .rsp_index(rsp_unknown_index),
      .rsp_value(rsp_solution_value), .rsp_status(rsp_status),
      .rsp_last(rsp_last_flag));
endmodule

FILE: test/gauss_seidel_solver_unit_tb.sv
// ---------------------------------------------------------------------------
// gauss_seidel_solver_unit_tb
// Self-checking regression for the 3x3 Gauss-Seidel solver unit.
// Matrix loads and solve commands go in through the start/busy port. A
// behavioral predictor does the row normalization and the sweeps in exact
// fixed point and queues the three expected solution transactions per
// solve. A monitor compares each strobed result with the oldest
// expectation. The sweep count is reprogrammed between phases over the
// csr port, and the random phases use sender idle rates 0/85/25 percent.
// ---------------------------------------------------------------------------
module gauss_seidel_solver_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]         idx;
      logic signed [31:0] value;
      logic               status;
      logic               last;
   } solution_type;

   logic clock, reset, start, busy;
   logic req_operation;
   logic [1:0] req_row_index, req_column_index;
   logic signed [31:0] req_entry_value;
   logic rsp_valid, rsp_status, rsp_last_flag;
   logic [1:0] rsp_unknown_index;
   logic signed [31:0] rsp_solution_value;
   logic psel, penable, pwrite, pready;
   logic [1:0] paddr;
   logic [31:0] pwdata, prdata;

   // predictor state
   logic signed [31:0] matrix_model [gss_pkg::SIZE][gss_pkg::COLS];
   logic signed [31:0] iterate_model [gss_pkg::SIZE];
   logic [gss_pkg::SWEEP_W-1:0] sweeps_model;
   solution_type solution_queue [$];

   int errors = 0;
   int solves_sent = 0;
   int loads_sent = 0;
   int results_seen = 0;
   int idle_pct = 0;

   gauss_seidel_solver_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("gauss_seidel_solver_unit regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // (a << FRAC_BITS) / d, truncated toward zero, saturated
   function automatic logic signed [31:0] fx_quotient(input logic signed [31:0] a,
                                                      input logic signed [31:0] d);
      longint unsigned ma, md, q;
      ma = (a < 0) ? -longint'(a) : longint'(a);
      md = (d < 0) ? -longint'(d) : longint'(d);
      q = (ma << gss_pkg::FRAC_BITS) / md;
      if ((a < 0) != (d < 0)) begin
         if (q > 64'h80000000) q = 64'h80000000;
         return 32'(-longint'(q));
      end
      if (q > 64'h7fffffff) q = 64'h7fffffff;
      return 32'(q);
   endfunction

   function automatic longint fx_product(input logic signed [31:0] c,
                                         input logic signed [31:0] x);
      longint unsigned mc, mx, m;
      mc = (c < 0) ? -longint'(c) : longint'(c);
      mx = (x < 0) ? -longint'(x) : longint'(x);
      m = (mc * mx) >> gss_pkg::FRAC_BITS;
      return ((c < 0) != (x < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

   // normalize rows, sweep from zero, queue one transaction per unknown
   task automatic predict_solution();
      logic signed [31:0] coef [gss_pkg::SIZE][gss_pkg::SIZE];
      logic signed [31:0] rhs [gss_pkg::SIZE];
      logic zero_diag;
      longint acc;
      solution_type r;
      zero_diag = 1'b0;
      for (int i = 0; i < gss_pkg::SIZE; i++) begin
         if (matrix_model[i][i] == 0) begin
            zero_diag = 1'b1;
            for (int j = 0; j < gss_pkg::SIZE; j++) coef[i][j] = 0;
            rhs[i] = 0;
         end else begin
            for (int j = 0; j < gss_pkg::SIZE; j++)
               coef[i][j] = (i == j) ? 32'sd0
                          : fx_quotient(matrix_model[i][j], matrix_model[i][i]);
            rhs[i] = fx_quotient(matrix_model[i][gss_pkg::SIZE], matrix_model[i][i]);
         end
      end
      for (int i = 0; i < gss_pkg::SIZE; i++) iterate_model[i] = 0;
      for (int s = 0; s < sweeps_model; s++)
         for (int j = 0; j < gss_pkg::SIZE; j++) begin
            acc = 0;
            for (int k = 0; k < gss_pkg::SIZE; k++)
               acc += fx_product(coef[j][k], iterate_model[k]);
            iterate_model[j] = clamp32(longint'(rhs[j]) - acc);
         end
      for (int j = 0; j < gss_pkg::SIZE; j++) begin
         r.idx = 2'(j);
         r.value = iterate_model[j];
         r.status = zero_diag;
         r.last = (j == gss_pkg::SIZE - 1);
         solution_queue.push_back(r);
      end
   endtask

   // one transaction; called and returns just after a falling edge
   task automatic send_item(input logic op, input logic [1:0] row, input logic [1:0] col,
                            input logic signed [31:0] value);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      while (busy) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_operation = op;
      req_row_index = row;
      req_column_index = col;
      req_entry_value = value;
      start = 1'b1;
      if (op == gss_pkg::OP_SOLVE) begin
         predict_solution();
         solves_sent++;
      end else begin
         if (row < gss_pkg::SIZE) matrix_model[row][col] = value;
         loads_sent++;
      end
      @(negedge clock);
   endtask

   // hold off until every expected result is in and the unit is idle
   task automatic drain();
      int guard;
      guard = 0;
      start = 1'b0;
      while ((solution_queue.size() != 0 || busy) && guard < 400000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] data, output logic [31:0] rd);
      start = 1'b0;
      psel = 1'b1;
      pwrite = wr;
      penable = 1'b0;
      paddr = 2'(4 * gss_pkg::REG_SWEEP_COUNT);
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      rd = prdata;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_sweeps(input logic [gss_pkg::SWEEP_W-1:0] n);
      logic [31:0] rd;
      drain();
      csr_access(1'b1, 32'(n), rd);
      sweeps_model = n;
      csr_access(1'b0, 32'd0, rd);
      if (rd[gss_pkg::SWEEP_W-1:0] !== n) report_mismatch("sweep_count readback", rd, n);
   endtask

   function automatic logic signed [31:0] diag_value();
      logic signed [31:0] v;
      v = ($urandom_range(2, 8) << gss_pkg::FRAC_BITS) + $urandom_range(0, 65535);
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic logic signed [31:0] wellformed_value(input int row, input int col);
      logic signed [31:0] v;
      if (row == col) return diag_value();
      if (col == gss_pkg::SIZE) v = $urandom_range(0, 100 << gss_pkg::FRAC_BITS);
      else v = $urandom_range(0, 65535);
      return $urandom_range(1) ? -v : v;
   endfunction

   task automatic load_wellformed_matrix();
      for (int r = 0; r < gss_pkg::SIZE; r++)
         for (int c = 0; c < gss_pkg::COLS; c++)
            send_item(gss_pkg::OP_LOAD, 2'(r), 2'(c), wellformed_value(r, c));
   endtask

   // full matrix, extremes, zero diagonal, ignored row, tiny diagonal
   task automatic test_directed();
      load_wellformed_matrix();
      send_item(gss_pkg::OP_SOLVE, 2'd0, 2'd0, 32'sd0);
      send_item(gss_pkg::OP_LOAD, 2'd3, 2'd1, 32'sh7fffffff);
      send_item(gss_pkg::OP_LOAD, 2'd0, 2'd0, 32'sd0);
      send_item(gss_pkg::OP_SOLVE, 2'd3, 2'd3, 32'shffffffff);
      send_item(gss_pkg::OP_LOAD, 2'd0, 2'd0, 32'sh80000000);
      send_item(gss_pkg::OP_LOAD, 2'd1, 2'd3, 32'sh7fffffff);
      send_item(gss_pkg::OP_LOAD, 2'd2, 2'd2, 32'sd1);
      send_item(gss_pkg::OP_LOAD, 2'd2, 2'd3, 32'sh80000000);
      send_item(gss_pkg::OP_SOLVE, 2'd0, 2'd0, 32'sd0);
      drain();
   endtask

   // zero, one and the full-range sweep count
   task automatic test_sweep_extremes();
      set_sweeps(8'd0);
      send_item(gss_pkg::OP_SOLVE, 2'd0, 2'd0, 32'sd0);
      set_sweeps(8'd1);
      load_wellformed_matrix();
      send_item(gss_pkg::OP_SOLVE, 2'd0, 2'd0, 32'sd0);
      set_sweeps(8'd255);
      send_item(gss_pkg::OP_SOLVE, 2'd0, 2'd0, 32'sd0);
      send_item(gss_pkg::OP_LOAD, 2'd1, 2'd0, 32'sh7fffffff);
      send_item(gss_pkg::OP_SOLVE, 2'd0, 2'd0, 32'sd0);
      drain();
   endtask

   // mostly well-formed reload-and-solve sequences, some noise
   task automatic test_random(input int n_items, input int pct);
      int sent, nloads, r, c;
      sent = 0;
      idle_pct = pct;
      set_sweeps(8'($urandom_range(1, 24)));
      while (sent < n_items) begin
         if ($urandom_range(99) < 70) begin
            nloads = $urandom_range(1, 6);
            repeat (nloads) begin
               r = $urandom_range(0, gss_pkg::SIZE - 1);
               c = $urandom_range(0, gss_pkg::SIZE);
               send_item(gss_pkg::OP_LOAD, 2'(r), 2'(c), wellformed_value(r, c));
            end
            send_item(gss_pkg::OP_SOLVE, 2'($urandom), 2'($urandom), $urandom);
            sent += nloads + 1;
         end else begin
            r = $urandom_range(0, 3);
            c = $urandom_range(0, 3);
            if ($urandom_range(3) == 0) send_item(gss_pkg::OP_LOAD, 2'(r), 2'(r), 32'sd0);
            else send_item(1'($urandom), 2'(r), 2'(c), $urandom);
            if (r < gss_pkg::SIZE) sent++;
         end
         // pause until every result is back
         if ($urandom_range(15) == 0) drain();
      end
      drain();
      idle_pct = 0;
   endtask

   always @(posedge clock) begin
      solution_type w;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (solution_queue.size() == 0) begin
            report_mismatch("unexpected result, index", rsp_unknown_index, -1);
         end else begin
            w = solution_queue.pop_front();
            if (rsp_unknown_index !== w.idx)
               report_mismatch("unknown_index", rsp_unknown_index, w.idx);
            if (rsp_solution_value !== w.value)
               report_mismatch("solution_value", rsp_solution_value, w.value);
            if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            if (rsp_last_flag !== w.last) report_mismatch("last_flag", rsp_last_flag, w.last);
         end
      end
   end

   initial begin
      logic [31:0] rd;
      reset = 1'b1;
      start = 1'b0;
      req_operation = gss_pkg::OP_LOAD;
      req_row_index = 2'd0;
      req_column_index = 2'd0;
      req_entry_value = 32'sd0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 2'd0;
      pwdata = 32'd0;
      sweeps_model = gss_pkg::SWEEP_RESET;
      for (int i = 0; i < gss_pkg::SIZE; i++) iterate_model[i] = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      csr_access(1'b0, 32'd0, rd);
      if (rd[gss_pkg::SWEEP_W-1:0] !== gss_pkg::SWEEP_RESET)
         report_mismatch("sweep_count reset", rd, gss_pkg::SWEEP_RESET);

      test_directed();
      test_sweep_extremes();
      test_random(55, 0);
      test_random(50, 85);
      test_random(45, 25);
      test_random(40, 0);
      drain();
      repeat (50) @(negedge clock);
      if (solution_queue.size() != 0)
         report_mismatch("results still outstanding", solution_queue.size(), 0);

      $display("Covered %0d loads and %0d solves, %0d results checked,", loads_sent,
               solves_sent, results_seen);
      $display("sweep counts 0, 1, 32, 255 and random, sender idle 0/85/25 percent.");
      if (errors == 0) begin
         $display("gauss_seidel_solver_unit regression: pass");
      end else begin
         $display("gauss_seidel_solver_unit regression: fail");
      end
      $finish;
   end
endmodule
